// ===== sv/mips_control_flow_decode_defines.svh =====
// Assertion macros for the decoder's top-level RTL file.
// Each macro expects clk and rst_n in scope.
`ifndef MIPS_CONTROL_FLOW_DECODE_DEFINES_SVH
`define MIPS_CONTROL_FLOW_DECODE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MCFD_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mcfd: implication check failed");

// Next-cycle implication, checked outside reset.
`define MCFD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mcfd: next-cycle check failed");

`endif

// ===== sv/mcfd_pkg.sv =====
`default_nettype none

package mcfd_pkg;

    // Input beat: one instruction and its address
    typedef struct packed {
        logic [31:0] instruction_word;
        logic [31:0] instruction_address;
    } mcfd_in_t;

    // Result beat
    typedef struct packed {
        logic        is_branch;
        logic        is_conditional;
        logic        is_indirect;
        logic        is_call;
        logic        writes_register;
        logic [4:0]  dest_register;
        logic [31:0] target_address;
        logic        invalid_encoding;
    } mcfd_out_t;

    // Control-transfer class handed from the decoder to the target unit
    typedef struct packed {
        logic br;
        logic cond;
        logic ind;
        logic call;
        logic jump;    // J or JAL: region-relative target
    } mcfd_ctl_t;

    localparam int unsigned INSN_BYTES = 4;

    // Coprocessor fields
    localparam logic [4:0] COP_BRANCH_RS = 5'd8;
    localparam logic [1:0] COP_SEL_MASK  = 2'b11;
    localparam logic [1:0] COP_SEL_CP0   = 2'd0;
    localparam logic [4:0] COP_RS_MF     = 5'd0;
    localparam logic [4:0] COP_RS_DMF    = 5'd1;
    localparam logic [4:0] COP_RS_CF     = 5'd2;

    // Major opcodes
    localparam logic [5:0] OP_SPECIAL = 6'd0;
    localparam logic [5:0] OP_REGIMM  = 6'd1;
    localparam logic [5:0] OP_J       = 6'd2;
    localparam logic [5:0] OP_JAL     = 6'd3;
    localparam logic [5:0] OP_BEQ     = 6'd4;
    localparam logic [5:0] OP_BNE     = 6'd5;
    localparam logic [5:0] OP_BLEZ    = 6'd6;
    localparam logic [5:0] OP_BGTZ    = 6'd7;
    localparam logic [5:0] OP_ADDI    = 6'd8;
    localparam logic [5:0] OP_ADDIU   = 6'd9;
    localparam logic [5:0] OP_SLTI    = 6'd10;
    localparam logic [5:0] OP_SLTIU   = 6'd11;
    localparam logic [5:0] OP_ANDI    = 6'd12;
    localparam logic [5:0] OP_ORI     = 6'd13;
    localparam logic [5:0] OP_XORI    = 6'd14;
    localparam logic [5:0] OP_LUI     = 6'd15;
    localparam logic [5:0] OP_COP0    = 6'd16;
    localparam logic [5:0] OP_COP1    = 6'd17;
    localparam logic [5:0] OP_COP2    = 6'd18;
    localparam logic [5:0] OP_COP1X   = 6'd19;
    localparam logic [5:0] OP_BEQL    = 6'd20;
    localparam logic [5:0] OP_BNEL    = 6'd21;
    localparam logic [5:0] OP_BLEZL   = 6'd22;
    localparam logic [5:0] OP_BGTZL   = 6'd23;
    localparam logic [5:0] OP_DADDI   = 6'd24;
    localparam logic [5:0] OP_DADDIU  = 6'd25;
    localparam logic [5:0] OP_LDL     = 6'd26;
    localparam logic [5:0] OP_LDR     = 6'd27;
    localparam logic [5:0] OP_LB      = 6'd32;
    localparam logic [5:0] OP_LH      = 6'd33;
    localparam logic [5:0] OP_LWL     = 6'd34;
    localparam logic [5:0] OP_LW      = 6'd35;
    localparam logic [5:0] OP_LBU     = 6'd36;
    localparam logic [5:0] OP_LHU     = 6'd37;
    localparam logic [5:0] OP_LWR     = 6'd38;
    localparam logic [5:0] OP_LWU     = 6'd39;
    localparam logic [5:0] OP_LL      = 6'd48;
    localparam logic [5:0] OP_LLD     = 6'd52;
    localparam logic [5:0] OP_LD      = 6'd55;

    // REGIMM rt codes
    localparam logic [4:0] RT_BLTZ    = 5'd0;
    localparam logic [4:0] RT_BGEZ    = 5'd1;
    localparam logic [4:0] RT_BLTZL   = 5'd2;
    localparam logic [4:0] RT_BGEZL   = 5'd3;
    localparam logic [4:0] RT_BLTZAL  = 5'd16;
    localparam logic [4:0] RT_BGEZAL  = 5'd17;
    localparam logic [4:0] RT_BLTZALL = 5'd18;
    localparam logic [4:0] RT_BGEZALL = 5'd19;

    // SPECIAL function codes
    localparam logic [5:0] FN_SLL    = 6'd0;
    localparam logic [5:0] FN_SRL    = 6'd2;
    localparam logic [5:0] FN_SRA    = 6'd3;
    localparam logic [5:0] FN_SLLV   = 6'd4;
    localparam logic [5:0] FN_SRLV   = 6'd6;
    localparam logic [5:0] FN_SRAV   = 6'd7;
    localparam logic [5:0] FN_JR     = 6'd8;
    localparam logic [5:0] FN_JALR   = 6'd9;
    localparam logic [5:0] FN_MFHI   = 6'd16;
    localparam logic [5:0] FN_MFLO   = 6'd18;
    localparam logic [5:0] FN_DSLLV  = 6'd20;
    localparam logic [5:0] FN_DSRLV  = 6'd22;
    localparam logic [5:0] FN_DSRAV  = 6'd23;
    localparam logic [5:0] FN_ADD    = 6'd32;
    localparam logic [5:0] FN_ADDU   = 6'd33;
    localparam logic [5:0] FN_SUB    = 6'd34;
    localparam logic [5:0] FN_SUBU   = 6'd35;
    localparam logic [5:0] FN_AND    = 6'd36;
    localparam logic [5:0] FN_OR     = 6'd37;
    localparam logic [5:0] FN_XOR    = 6'd38;
    localparam logic [5:0] FN_NOR    = 6'd39;
    localparam logic [5:0] FN_SLT    = 6'd42;
    localparam logic [5:0] FN_SLTU   = 6'd43;
    localparam logic [5:0] FN_DADD   = 6'd44;
    localparam logic [5:0] FN_DADDU  = 6'd45;
    localparam logic [5:0] FN_DSUB   = 6'd46;
    localparam logic [5:0] FN_DSUBU  = 6'd47;
    localparam logic [5:0] FN_DSLL   = 6'd56;
    localparam logic [5:0] FN_DSRL   = 6'd58;
    localparam logic [5:0] FN_DSRA   = 6'd59;
    localparam logic [5:0] FN_DSLL32 = 6'd60;
    localparam logic [5:0] FN_DSRL32 = 6'd62;
    localparam logic [5:0] FN_DSRA32 = 6'd63;

endpackage

`default_nettype wire

// ===== sv/mcfd_decode.sv =====
`default_nettype none

module mcfd_decode (
    input  wire logic [31:0]       instruction_word,
    output mcfd_pkg::mcfd_ctl_t    ctl,
    output logic                   writes_register,
    output logic [4:0]             dest_register,
    output logic                   invalid_encoding
);
    import mcfd_pkg::*;

    logic [5:0] op;
    logic [4:0] rs;
    logic [4:0] rt;
    logic [4:0] rd;
    logic [4:0] sa;
    logic [5:0] fn;
    logic [1:0] cop;

    assign op  = instruction_word[31:26];
    assign rs  = instruction_word[25:21];
    assign rt  = instruction_word[20:16];
    assign rd  = instruction_word[15:11];
    assign sa  = instruction_word[10:6];
    assign fn  = instruction_word[5:0];
    assign cop = op[1:0] & COP_SEL_MASK;

    // Control-transfer classification
    always_comb
    begin
        ctl              = '0;
        invalid_encoding = 1'b0;
        case (op)
            OP_COP0, OP_COP1, OP_COP2, OP_COP1X:
            begin
                if (rs == COP_BRANCH_RS)
                begin
                    ctl.br   = 1'b1;
                    ctl.cond = 1'b1;
                end
            end
            OP_BEQ, OP_BNE, OP_BEQL, OP_BNEL:
            begin
                // equal operands make the outcome fixed
                ctl.br   = 1'b1;
                ctl.cond = (rs != rt);
            end
            OP_BLEZ, OP_BGTZ, OP_BLEZL, OP_BGTZL:
            begin
                ctl.br   = 1'b1;
                ctl.cond = 1'b1;
            end
            OP_J:
            begin
                ctl.br   = 1'b1;
                ctl.jump = 1'b1;
            end
            OP_JAL:
            begin
                ctl.br   = 1'b1;
                ctl.call = 1'b1;
                ctl.jump = 1'b1;
            end
            OP_REGIMM:
            begin
                case (rt)
                    RT_BLTZ, RT_BGEZ, RT_BLTZL, RT_BGEZL:
                    begin
                        ctl.br   = 1'b1;
                        ctl.cond = 1'b1;
                    end
                    RT_BLTZAL, RT_BGEZAL, RT_BLTZALL, RT_BGEZALL:
                    begin
                        ctl.br   = 1'b1;
                        ctl.cond = 1'b1;
                        ctl.call = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end
            OP_SPECIAL:
            begin
                if (fn == FN_JALR)
                begin
                    if (rt == '0 && sa == '0)
                    begin
                        ctl.br   = 1'b1;
                        ctl.ind  = 1'b1;
                        ctl.call = 1'b1;
                    end
                    else
                        invalid_encoding = 1'b1;
                end
                else if (fn == FN_JR)
                begin
                    if (rt == '0 && rd == '0 && sa == '0)
                    begin
                        ctl.br  = 1'b1;
                        ctl.ind = 1'b1;
                    end
                    else
                        invalid_encoding = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // General register write decode; r0 writes still count
    always_comb
    begin
        writes_register = 1'b0;
        dest_register   = '0;
        if (op inside {OP_ADDI, OP_ADDIU, OP_SLTI, OP_SLTIU, OP_ANDI, OP_ORI, OP_XORI,
                       OP_LUI, OP_DADDI, OP_DADDIU, OP_LDL, OP_LDR, OP_LB, OP_LH,
                       OP_LWL, OP_LW, OP_LBU, OP_LHU, OP_LWR, OP_LWU, OP_LL, OP_LLD,
                       OP_LD})
        begin
            writes_register = 1'b1;
            dest_register   = rt;
        end
        else if (op inside {OP_COP0, OP_COP1, OP_COP2})
        begin
            // moves from coprocessor registers
            if (sa == '0 && fn == '0 &&
                ((cop == COP_SEL_CP0 && rs == COP_RS_DMF) ||
                 (cop != COP_SEL_CP0 && rs == COP_RS_CF) ||
                 rs == COP_RS_MF))
            begin
                writes_register = 1'b1;
                dest_register   = rt;
            end
        end
        else if (op == OP_SPECIAL)
        begin
            if (fn inside {FN_SLLV, FN_SRLV, FN_SRAV, FN_DSLLV, FN_DSRLV, FN_DSRAV,
                           FN_ADD, FN_ADDU, FN_SUB, FN_SUBU, FN_AND, FN_OR, FN_XOR,
                           FN_NOR, FN_SLT, FN_SLTU, FN_DADD, FN_DADDU, FN_DSUB,
                           FN_DSUBU})
                writes_register = (sa == '0);
            else if (fn inside {FN_SLL, FN_SRL, FN_SRA, FN_DSLL, FN_DSRL, FN_DSRA,
                                FN_DSLL32, FN_DSRL32, FN_DSRA32})
                writes_register = (rs == '0);
            else if (fn inside {FN_MFHI, FN_MFLO})
                writes_register = (rs == '0 && rt == '0 && sa == '0);
            else if (fn == FN_JALR)
                writes_register = (rt == '0 && sa == '0);
            if (writes_register)
                dest_register = rd;
        end
    end

endmodule

`default_nettype wire

// ===== sv/mcfd_target.sv =====
`default_nettype none

module mcfd_target #(
    parameter int unsigned ADDRESS_WIDTH = 32
) (
    input  wire logic [31:0]       instruction_word,
    input  wire logic [31:0]       instruction_address,
    input  wire mcfd_pkg::mcfd_ctl_t ctl,
    output logic [31:0]            target_address
);
    import mcfd_pkg::*;

    localparam int unsigned AW = ADDRESS_WIDTH;

    logic [AW-1:0] slot;
    logic [AW-1:0] region_target;
    logic [AW-1:0] rel_target;
    logic [AW-1:0] offset;

    // Delay-slot address at full address width
    assign slot = AW'(instruction_address) + AW'(INSN_BYTES);

    // J/JAL: keep region bits of the slot, splice in imm26 << 2
    assign region_target = {slot[AW-1:28], instruction_word[25:0], 2'b00};

    // Branches: slot plus sign-extended word offset
    assign offset     = AW'({{(AW-18){instruction_word[15]}}, instruction_word[15:0], 2'b00});
    assign rel_target = slot + offset;

    always_comb
    begin
        if (!ctl.br || ctl.ind)
            target_address = '0;
        else if (ctl.jump)
            target_address = region_target[31:0];
        else
            target_address = rel_target[31:0];
    end

endmodule

`default_nettype wire

// ===== sv/mips_control_flow_decode.sv =====
// MIPS IV control-flow decoder. Each beat carries one instruction word and its
// byte address; the result beat reports branch/jump/call class, register write
// and direct target. The block is a two-register pipeline (input register,
// decode logic, result register): a beat taken into the input register is
// decoded and loaded into the result register once that register is free or
// draining, and one beat is accepted every cycle as long as the result side
// keeps taking beats. in_ready drops only when both registers hold beats and
// out_ready is low. ADDRESS_WIDTH sets the width of the target adders; the
// reported target is the low 32 bits.
`default_nettype none

`include "mips_control_flow_decode_defines.svh"

module mips_control_flow_decode #(
    parameter int unsigned ADDRESS_WIDTH = 32
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire mcfd_pkg::mcfd_in_t  in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output mcfd_pkg::mcfd_out_t    out_data
);
    import mcfd_pkg::*;

    logic      s1_valid_reg;
    logic      s1_valid_next;
    mcfd_in_t  s1_data_reg;
    logic      out_valid_reg;
    logic      out_valid_next;
    mcfd_out_t out_data_reg;
    mcfd_out_t out_data_next;
    logic      in_fire;
    logic      s1_adv;

    mcfd_ctl_t   ctl;
    logic        dec_wr;
    logic [4:0]  dec_rd;
    logic        dec_bad;
    logic [31:0] dec_target;

    // Handshake: stage 1 moves on when the result register is free or draining
    assign s1_adv   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_adv;
    assign in_fire  = in_valid && in_ready;

    assign s1_valid_next  = in_fire ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);
    assign out_valid_next = s1_adv ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
            s1_data_reg <= in_data;
        if (s1_adv)
            out_data_reg <= out_data_next;
    end

    mcfd_decode u_decode (
        .instruction_word (s1_data_reg.instruction_word),
        .ctl              (ctl),
        .writes_register  (dec_wr),
        .dest_register    (dec_rd),
        .invalid_encoding (dec_bad)
    );

    mcfd_target #(
        .ADDRESS_WIDTH (ADDRESS_WIDTH)
    ) u_target (
        .instruction_word    (s1_data_reg.instruction_word),
        .instruction_address (s1_data_reg.instruction_address),
        .ctl                 (ctl),
        .target_address      (dec_target)
    );

    // Assemble the result beat
    always_comb
    begin
        out_data_next.is_branch        = ctl.br;
        out_data_next.is_conditional   = ctl.cond;
        out_data_next.is_indirect      = ctl.ind;
        out_data_next.is_call          = ctl.call;
        out_data_next.writes_register  = dec_wr;
        out_data_next.dest_register    = dec_rd;
        out_data_next.target_address   = dec_target;
        out_data_next.invalid_encoding = dec_bad;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Checks
    `MCFD_ASSERT_NEXT(a_stage_moves, s1_adv, out_valid)
    `MCFD_ASSERT_IMPL(a_flags_need_branch,
        out_valid && (out_data.is_conditional || out_data.is_indirect || out_data.is_call),
        out_data.is_branch)
    `MCFD_ASSERT_IMPL(a_bad_no_effect, out_valid && out_data.invalid_encoding,
        !out_data.is_branch && !out_data.writes_register)
    `MCFD_ASSERT_IMPL(a_no_write_no_dest, out_valid && !out_data.writes_register,
        out_data.dest_register == '0)
    `MCFD_ASSERT_IMPL(a_no_target, out_valid && (!out_data.is_branch || out_data.is_indirect),
        out_data.target_address == '0)

endmodule

`default_nettype wire
